// ===== design/ocsd_pkg.sv =====
// shared types, role codes and opcode length table of the object code stream decoder
`default_nettype none
package ocsd_pkg;

  localparam logic [7:0] MARKER_BYTE  = 8'hDD;
  localparam logic [7:0] PREFIX_BYTE  = 8'hCB;
  localparam logic [3:0] HEADER_BYTES = 4'd8;

  localparam logic [3:0] ROLE_HEADER  = 4'd0;
  localparam logic [3:0] ROLE_OPCODE  = 4'd1;
  localparam logic [3:0] ROLE_CB_PFX  = 4'd2;
  localparam logic [3:0] ROLE_CB_SUB  = 4'd3;
  localparam logic [3:0] ROLE_OPND_LO = 4'd4;
  localparam logic [3:0] ROLE_OPND_HI = 4'd5;
  localparam logic [3:0] ROLE_SIGN    = 4'd6;
  localparam logic [3:0] ROLE_MARKER  = 4'd7;
  localparam logic [3:0] ROLE_COUNT   = 4'd8;
  localparam logic [3:0] ROLE_DATA    = 4'd9;
  localparam logic [3:0] ROLE_BAD_OP  = 4'd10;
  localparam logic [3:0] ROLE_OVERRUN = 4'd11;

  typedef struct packed {
    logic [3:0]  role;
    logic [7:0]  value;
    logic [1:0]  ilen;
    logic [31:0] addr;
    logic [31:0] slen;
    logic        done;
    logic        last;
  } res_t;

  localparam logic [1:0] LEN_TABLE [256] = '{
    2'd1,2'd3,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,2'd3,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,
    2'd1,2'd3,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,2'd2,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,
    2'd2,2'd3,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,2'd2,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,
    2'd2,2'd3,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,2'd2,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd1,2'd1,2'd3,2'd3,2'd3,2'd1,2'd2,2'd1,2'd1,2'd1,2'd3,2'd2,2'd3,2'd3,2'd2,2'd1,
    2'd1,2'd1,2'd3,2'd0,2'd3,2'd1,2'd2,2'd1,2'd1,2'd1,2'd3,2'd0,2'd3,2'd0,2'd2,2'd1,
    2'd2,2'd1,2'd1,2'd0,2'd0,2'd1,2'd2,2'd1,2'd2,2'd1,2'd3,2'd0,2'd0,2'd0,2'd2,2'd1,
    2'd2,2'd1,2'd1,2'd1,2'd0,2'd1,2'd2,2'd1,2'd2,2'd1,2'd3,2'd1,2'd0,2'd0,2'd2,2'd1
  };

  function automatic res_t mk_res(input logic [3:0] role, input logic [7:0] value,
                                  input logic [1:0] ilen);
    res_t r;
    r       = '0;
    r.role  = role;
    r.value = value;
    r.ilen  = ilen;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/ocsd_in_if.sv =====
// input byte channel of the object code stream decoder
`default_nettype none
interface ocsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface
`default_nettype wire

// ===== design/ocsd_out_if.sv =====
// tagged byte result channel of the object code stream decoder
`default_nettype none
interface ocsd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  byte_role;
  logic [7:0]  byte_value;
  logic [1:0]  instruction_length;
  logic [31:0] section_address;
  logic [31:0] section_size;
  logic        section_done;
  logic        last;

  modport source (output valid, output byte_role, output byte_value,
                  output instruction_length, output section_address,
                  output section_size, output section_done, output last,
                  input ready);
  modport sink   (input valid, input byte_role, input byte_value,
                  input instruction_length, input section_address,
                  input section_size, input section_done, input last,
                  output ready);
endinterface
`default_nettype wire

// ===== design/object_code_stream_decoder.sv =====
// top level: tags each byte of an object file code area with its role
//
// in_chan carries one raw code byte per transfer, out_chan one tagged byte per
// transfer; cfg_wr_en/cfg_wr_data load the code area length; the user writes it
// only while idle, the block does not enforce this. a byte is decoded in the
// cycle it is taken and its results (zero to three) land in a four-entry result
// queue, which is registered: no result reaches out_chan in that same cycle.
// throughput: one byte per cycle while each byte yields at most one result
// and the receiver is ready; a byte that releases held 0xdd bytes yields two
// or three results, drained at one per cycle, set by the single output port.
// in_chan.ready is high while at most one result waits in the queue, so a new
// byte is taken even while the receiver holds off a finished result.
// a 0xdd held in look-ahead yields no result until the next byte decides it.
// reset (rst_n low, synchronous) empties the queue, clears all decode state
// and sets the code area length to zero.
// when the receiver stalls, the queue fills and in_chan.ready drops; no
// result is lost or repeated.
`default_nettype none
module object_code_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  ocsd_in_if.sink          in_chan,
  ocsd_out_if.source       out_chan
);
  import ocsd_pkg::*;

  localparam int QDEPTH = 4;

  logic [31:0] cfg_len_r;
  logic [3:0]  hdr_cnt_r,   hdr_cnt_nxt;
  logic [31:0] addr_r,      addr_nxt;
  logic [31:0] slen_r,      slen_nxt;
  logic [31:0] rem_r,       rem_nxt;
  logic [31:0] consumed_r,  consumed_nxt;
  logic [1:0]  held_r,      held_nxt;
  logic [1:0]  opnd_r,      opnd_nxt;
  logic [1:0]  cur_len_r,   cur_len_nxt;
  logic        prefix_r,    prefix_nxt;
  logic [1:0]  cphase_r,    cphase_nxt;
  logic [15:0] data_left_r, data_left_nxt;

  res_t        queue_r [QDEPTH];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  cnt_r;

  res_t        ent [QDEPTH];
  res_t        dec;
  logic [1:0]  n_res;
  logic        end_sec;
  logic [7:0]  b;
  logic [1:0]  tlen;
  logic        push, pop;

  assign b    = in_chan.code_byte;
  assign tlen = LEN_TABLE[b];

  assign in_chan.ready = (cnt_r <= 3'd1);
  assign push          = in_chan.valid && in_chan.ready;
  assign pop           = out_chan.valid && out_chan.ready;

  always_comb begin
    hdr_cnt_nxt   = hdr_cnt_r;
    addr_nxt      = addr_r;
    slen_nxt      = slen_r;
    rem_nxt       = rem_r;
    consumed_nxt  = consumed_r;
    held_nxt      = held_r;
    opnd_nxt      = opnd_r;
    cur_len_nxt   = cur_len_r;
    prefix_nxt    = prefix_r;
    cphase_nxt    = cphase_r;
    data_left_nxt = data_left_r;
    end_sec       = 1'b0;
    n_res         = 2'd0;
    for (int i = 0; i < QDEPTH; i++) begin
      ent[i] = '0;
    end

    // opcode decode after any held markers are released
    if (b == PREFIX_BYTE) begin
      dec = mk_res(ROLE_CB_PFX, b, 2'd2);
    end else if (tlen == 2'd0) begin
      dec = mk_res(ROLE_BAD_OP, b, 2'd0);
    end else begin
      dec = mk_res(ROLE_OPCODE, b, tlen);
    end

    if (hdr_cnt_r == 4'd0 && consumed_r >= cfg_len_r) begin
      n_res  = 2'd1;
      ent[0] = mk_res(ROLE_OVERRUN, b, 2'd0);
    end else begin
      if (consumed_r != '1) begin
        consumed_nxt = consumed_r + 32'd1;
      end
      if (hdr_cnt_r < HEADER_BYTES) begin
        if (hdr_cnt_r[2]) begin
          slen_nxt[{hdr_cnt_r[1:0], 3'b000} +: 8] = b;
        end else begin
          addr_nxt[{hdr_cnt_r[1:0], 3'b000} +: 8] = b;
        end
        hdr_cnt_nxt = hdr_cnt_r + 4'd1;
        if (hdr_cnt_nxt == HEADER_BYTES) begin
          rem_nxt = slen_nxt;
          if (slen_nxt == 32'd0) begin
            hdr_cnt_nxt = 4'd0;
            end_sec     = 1'b1;
          end
        end
        n_res  = 2'd1;
        ent[0] = mk_res(ROLE_HEADER, b, 2'd0);
      end else begin
        rem_nxt = rem_r - 32'd1;
        end_sec = (rem_r == 32'd1);
        if (cphase_r == 2'd1) begin
          n_res         = 2'd1;
          ent[0]        = mk_res(ROLE_COUNT, b, 2'd0);
          data_left_nxt = {b, 8'h00};
          cphase_nxt    = 2'd2;
        end else if (cphase_r == 2'd2) begin
          n_res         = 2'd1;
          ent[0]        = mk_res(ROLE_COUNT, b, 2'd0);
          data_left_nxt = {data_left_r[15:8], b};
          cphase_nxt    = 2'd0;
        end else if (data_left_r != 16'd0) begin
          n_res         = 2'd1;
          ent[0]        = mk_res(ROLE_DATA, b, 2'd0);
          data_left_nxt = data_left_r - 16'd1;
        end else if (opnd_r != 2'd0) begin
          n_res = 2'd1;
          if (opnd_r == 2'd1) begin
            ent[0] = mk_res(ROLE_SIGN, b, cur_len_r);
          end else if (opnd_r == cur_len_r) begin
            ent[0] = mk_res(ROLE_OPND_LO, b, cur_len_r);
          end else begin
            ent[0] = mk_res(ROLE_OPND_HI, b, cur_len_r);
          end
          opnd_nxt = opnd_r - 2'd1;
        end else if (prefix_r) begin
          n_res      = 2'd1;
          ent[0]     = mk_res(ROLE_CB_SUB, b, cur_len_r);
          prefix_nxt = 1'b0;
        end else if (b == MARKER_BYTE && held_r >= 2'd2) begin
          n_res      = 2'd3;
          ent[0]     = mk_res(ROLE_MARKER, MARKER_BYTE, 2'd0);
          ent[1]     = mk_res(ROLE_MARKER, MARKER_BYTE, 2'd0);
          ent[2]     = mk_res(ROLE_MARKER, b, 2'd0);
          held_nxt   = 2'd0;
          cphase_nxt = 2'd1;
        end else if (b == MARKER_BYTE && !end_sec) begin
          held_nxt = held_r + 2'd1;
        end else begin
          // release held markers as bad opcodes, then decode this byte
          n_res    = held_r + 2'd1;
          held_nxt = 2'd0;
          case (held_r)
            2'd0: begin
              ent[0] = dec;
            end
            2'd1: begin
              ent[0] = mk_res(ROLE_BAD_OP, MARKER_BYTE, 2'd0);
              ent[1] = dec;
            end
            default: begin
              ent[0] = mk_res(ROLE_BAD_OP, MARKER_BYTE, 2'd0);
              ent[1] = mk_res(ROLE_BAD_OP, MARKER_BYTE, 2'd0);
              ent[2] = dec;
            end
          endcase
          if (b == PREFIX_BYTE) begin
            cur_len_nxt = 2'd2;
            prefix_nxt  = 1'b1;
          end else if (tlen != 2'd0) begin
            cur_len_nxt = tlen;
            opnd_nxt    = (tlen > 2'd1) ? tlen : 2'd0;
          end
        end
        if (end_sec) begin
          hdr_cnt_nxt   = 4'd0;
          opnd_nxt      = 2'd0;
          prefix_nxt    = 1'b0;
          cphase_nxt    = 2'd0;
          data_left_nxt = 16'd0;
          held_nxt      = 2'd0;
        end
      end
    end

    for (int i = 0; i < QDEPTH; i++) begin
      ent[i].addr = addr_nxt;
      ent[i].slen = slen_nxt;
      ent[i].last = (2'(i) == n_res - 2'd1) && (n_res != 2'd0);
      ent[i].done = ent[i].last && end_sec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= '0;
      hdr_cnt_r   <= '0;
      addr_r      <= '0;
      slen_r      <= '0;
      rem_r       <= '0;
      consumed_r  <= '0;
      held_r      <= '0;
      opnd_r      <= '0;
      cur_len_r   <= '0;
      prefix_r    <= 1'b0;
      cphase_r    <= '0;
      data_left_r <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
      if (push) begin
        hdr_cnt_r   <= hdr_cnt_nxt;
        addr_r      <= addr_nxt;
        slen_r      <= slen_nxt;
        rem_r       <= rem_nxt;
        consumed_r  <= consumed_nxt;
        held_r      <= held_nxt;
        opnd_r      <= opnd_nxt;
        cur_len_r   <= cur_len_nxt;
        prefix_r    <= prefix_nxt;
        cphase_r    <= cphase_nxt;
        data_left_r <= data_left_nxt;
        wr_ptr_r    <= wr_ptr_r + n_res;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_r - {2'b00, pop} + (push ? {1'b0, n_res} : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (push && ((2'(i) - wr_ptr_r) < n_res)) begin
        queue_r[i] <= ent[2'(2'(i) - wr_ptr_r)];
      end
    end
  end

  assign out_chan.valid              = (cnt_r != 3'd0);
  assign out_chan.byte_role          = queue_r[rd_ptr_r].role;
  assign out_chan.byte_value         = queue_r[rd_ptr_r].value;
  assign out_chan.instruction_length = queue_r[rd_ptr_r].ilen;
  assign out_chan.section_address    = queue_r[rd_ptr_r].addr;
  assign out_chan.section_size       = queue_r[rd_ptr_r].slen;
  assign out_chan.section_done       = queue_r[rd_ptr_r].done;
  assign out_chan.last               = queue_r[rd_ptr_r].last;

endmodule
`default_nettype wire

// ===== tb/tb_object_code_stream_decoder.sv =====
// testbench for object_code_stream_decoder: byte-role predictor, scoreboard and drivers
`timescale 1ns / 1ps
module tb_object_code_stream_decoder;
  import ocsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 80;

  // one nibble per opcode, row = high nibble, leftmost digit = low nibble 0
  localparam logic [63:0] LEN_ROWS [16] = '{
    64'h1311_1121_3111_1121, 64'h1311_1121_2111_1121,
    64'h2311_1121_2111_1121, 64'h2311_1121_2111_1121,
    64'h1111_1111_1111_1111, 64'h1111_1111_1111_1111,
    64'h1111_1111_1111_1111, 64'h1111_1111_1111_1111,
    64'h1111_1111_1111_1111, 64'h1111_1111_1111_1111,
    64'h1111_1111_1111_1111, 64'h1111_1111_1111_1111,
    64'h1133_3121_1132_3321, 64'h1130_3121_1130_3021,
    64'h2110_0121_2130_0021, 64'h2111_0121_2131_0021
  };

  function automatic logic [1:0] op_len(input logic [7:0] b);
    logic [63:0] row;
    row = LEN_ROWS[b[7:4]];
    return row[60 - 4 * int'(b[3:0]) +: 2];
  endfunction

  class tag_scoreboard;
    res_t        pending_tags[$];
    res_t        step_tags[$];
    logic [31:0] area_len;
    logic [31:0] sec_addr;
    logic [31:0] sec_len;
    logic [31:0] body_left;
    logic [31:0] consumed;
    logic [3:0]  hdr_cnt;
    logic [1:0]  held_dd;
    logic [2:0]  opnd_left;
    logic [1:0]  cur_len;
    logic        cb_wait;
    logic [1:0]  cnt_phase;
    logic [15:0] data_left;
    int unsigned n_in;
    int unsigned n_out;
    int unsigned errors;
    int unsigned sections_closed;
    int unsigned role_hits [16];

    function new();
      area_len  = '0;
      sec_addr  = '0;
      sec_len   = '0;
      body_left = '0;
      consumed  = '0;
      hdr_cnt   = '0;
      held_dd   = '0;
      opnd_left = '0;
      cur_len   = '0;
      cb_wait   = 1'b0;
      cnt_phase = '0;
      data_left = '0;
      n_in = 0;
      n_out = 0;
      errors = 0;
      sections_closed = 0;
      foreach (role_hits[i]) role_hits[i] = 0;
    endfunction

    function void tag_byte(input logic [3:0] role, input logic [7:0] value,
                           input logic [1:0] ilen);
      res_t t;
      t.role  = role;
      t.value = value;
      t.ilen  = ilen;
      t.addr  = sec_addr;
      t.slen  = sec_len;
      t.done  = 1'b0;
      t.last  = 1'b0;
      step_tags.push_back(t);
    endfunction

    function void predict_tags(input logic [7:0] b);
      logic       closing;
      logic [3:0] role;
      int         sh;
      closing = 1'b0;
      step_tags.delete();
      n_in++;
      if (hdr_cnt == 0 && consumed >= area_len) begin
        tag_byte(ROLE_OVERRUN, b, 2'd0);
      end else begin
        if (consumed != '1) consumed++;
        if (hdr_cnt < HEADER_BYTES) begin
          sh = 8 * int'(hdr_cnt[1:0]);
          if (hdr_cnt < 4'd4) sec_addr[sh +: 8] = b;
          else sec_len[sh +: 8] = b;
          hdr_cnt++;
          if (hdr_cnt == HEADER_BYTES) begin
            body_left = sec_len;
            if (sec_len == 0) begin
              hdr_cnt = '0;
              closing = 1'b1;
            end
          end
          tag_byte(ROLE_HEADER, b, 2'd0);
        end else begin
          body_left--;
          closing = (body_left == 0);
          if (cnt_phase == 2'd1) begin
            tag_byte(ROLE_COUNT, b, 2'd0);
            data_left = {b, 8'h00};
            cnt_phase = 2'd2;
          end else if (cnt_phase == 2'd2) begin
            tag_byte(ROLE_COUNT, b, 2'd0);
            data_left[7:0] = b;
            cnt_phase = 2'd0;
          end else if (data_left != 0) begin
            tag_byte(ROLE_DATA, b, 2'd0);
            data_left--;
          end else if (opnd_left != 0) begin
            if (opnd_left == 3'd1) role = ROLE_SIGN;
            else if (opnd_left == {1'b0, cur_len}) role = ROLE_OPND_LO;
            else role = ROLE_OPND_HI;
            tag_byte(role, b, cur_len);
            opnd_left--;
          end else if (cb_wait) begin
            tag_byte(ROLE_CB_SUB, b, cur_len);
            cb_wait = 1'b0;
          end else if (b == MARKER_BYTE && held_dd >= 2'd2) begin
            repeat (3) tag_byte(ROLE_MARKER, MARKER_BYTE, 2'd0);
            held_dd = '0;
            cnt_phase = 2'd1;
          end else if (b == MARKER_BYTE && !closing) begin
            held_dd++;
          end else begin
            repeat (held_dd) tag_byte(ROLE_BAD_OP, MARKER_BYTE, 2'd0);
            held_dd = '0;
            if (b == PREFIX_BYTE) begin
              cur_len = 2'd2;
              cb_wait = 1'b1;
              tag_byte(ROLE_CB_PFX, b, 2'd2);
            end else if (op_len(b) == 2'd0) begin
              tag_byte(ROLE_BAD_OP, b, 2'd0);
            end else begin
              cur_len = op_len(b);
              opnd_left = (cur_len > 2'd1) ? {1'b0, cur_len} : 3'd0;
              tag_byte(ROLE_OPCODE, b, cur_len);
            end
          end
          if (closing) begin
            hdr_cnt   = '0;
            opnd_left = '0;
            cb_wait   = 1'b0;
            cnt_phase = '0;
            data_left = '0;
            held_dd   = '0;
          end
        end
      end
      if (step_tags.size() != 0) begin
        step_tags[step_tags.size() - 1].done = closing;
        step_tags[step_tags.size() - 1].last = 1'b1;
      end
      foreach (step_tags[i]) pending_tags.push_back(step_tags[i]);
    endfunction

    function void check_tag(input res_t got);
      res_t want;
      n_out++;
      role_hits[got.role]++;
      if (got.done) sections_closed++;
      if (pending_tags.size() == 0) begin
        if (errors < 10)
          $display("%0t: unexpected tag role %0d value %h", $realtime, got.role, got.value);
        errors++;
        return;
      end
      want = pending_tags.pop_front();
      if (got.role !== want.role || got.value !== want.value || got.ilen !== want.ilen ||
          got.addr !== want.addr || got.slen !== want.slen || got.done !== want.done ||
          got.last !== want.last) begin
        if (errors < 10) begin
          $display("%0t: mismatch (exp/got) role %0d/%0d value %h/%h ilen %0d/%0d",
                   $realtime, want.role, got.role, want.value, got.value,
                   want.ilen, got.ilen);
          $display("  addr %h/%h slen %h/%h done %b/%b last %b/%b",
                   want.addr, got.addr, want.slen, got.slen, want.done, got.done,
                   want.last, got.last);
        end
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        calm;
  logic        hold_armed;
  int unsigned cycle_count = 0;
  logic [7:0]  stim_q[$];
  res_t        seen_tag;
  tag_scoreboard sb;

  ocsd_in_if  in_ch ();
  ocsd_out_if out_ch ();

  object_code_stream_decoder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_ch),
    .out_chan    (out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tags outstanding", cycle_count,
               sb.pending_tags.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_tag.role  = out_ch.byte_role;
      seen_tag.value = out_ch.byte_value;
      seen_tag.ilen  = out_ch.instruction_length;
      seen_tag.addr  = out_ch.section_address;
      seen_tag.slen  = out_ch.section_size;
      seen_tag.done  = out_ch.section_done;
      seen_tag.last  = out_ch.last;
      sb.check_tag(seen_tag);
    end
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin : sink
    int unsigned hold_left;
    logic        hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic void add_section(input int unsigned body_len);
    logic [31:0] addr;
    logic [7:0]  body[$];
    logic [7:0]  op;
    logic [7:0]  cnt_lo;
    int unsigned k;
    addr = $urandom();
    for (k = 0; k < 4; k++) stim_q.push_back(addr[8*k +: 8]);
    stim_q.push_back(8'(body_len));
    repeat (3) stim_q.push_back(8'h00);
    while (body.size() < body_len) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          op = rand_byte();
          body.push_back(op);
          if (op == PREFIX_BYTE) body.push_back(rand_byte());
          else if (op_len(op) > 2'd1) repeat (op_len(op)) body.push_back(rand_byte());
        end
        4: begin
          body.push_back(PREFIX_BYTE);
          body.push_back(rand_byte());
        end
        5, 6: begin
          repeat (3) body.push_back(MARKER_BYTE);
          cnt_lo = 8'($urandom_range(6));
          body.push_back(($urandom_range(7) == 0) ? rand_byte() : 8'h00);
          body.push_back(cnt_lo);
          repeat (cnt_lo) body.push_back(rand_byte());
        end
        7: repeat ($urandom_range(1, 2)) body.push_back(MARKER_BYTE);
        8: body.push_back(rand_byte());
        default: begin
          do op = rand_byte(); while (op_len(op) != 2'd0 || op == MARKER_BYTE);
          body.push_back(op);
        end
      endcase
    end
    for (k = 0; k < body_len; k++) stim_q.push_back(body[k]);
  endfunction

  task automatic drive_stream();
    foreach (stim_q[i]) begin
      if (!calm && $urandom_range(99) < 38) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < 38);
      end
      in_ch.valid     <= 1'b1;
      in_ch.code_byte <= stim_q[i];
      do @(posedge clk); while (!in_ch.ready);
      sb.predict_tags(stim_q[i]);
    end
    in_ch.valid <= 1'b0;
    stim_q.delete();
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.pending_tags.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_area_length(input logic [31:0] len);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.area_len = len;
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned chunk;
    int unsigned chunks;
    sb = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    calm = 1'b0;
    hold_armed = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.code_byte = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty area: every byte overruns
    set_area_length(32'h0000_0000);
    stim_q = '{8'h00, 8'hFF};
    drive_stream();
    wait_drained();

    // empty section, then one section through lone markers, cb, operands,
    // a data directive and a marker as the closing byte
    set_area_length(32'hFFFF_FFFF);
    stim_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h11, 8'h00, 8'h00, 8'h00,
               8'h00, 8'hDD, 8'hDD, 8'hCB, 8'h7F, 8'hD3, 8'h01, 8'hFF,
               8'h00, 8'h80, 8'hDD, 8'hDD, 8'hDD, 8'h00, 8'h01, 8'h5A,
               8'hDD};
    drive_stream();
    wait_drained();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: set_area_length(sb.consumed + 32'd60);
        1: set_area_length(sb.consumed + 32'd130);
        default: set_area_length(32'hFFFF_FFFF);
      endcase
      calm = (ph == 1);
      chunks = (ph == 2) ? 2 : 1;
      for (chunk = 0; chunk < chunks; chunk++) begin
        while (stim_q.size() < 80 / chunks)
          add_section(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 40));
        if (chunk == chunks - 1) repeat (5) stim_q.push_back(rand_byte());
        if (ph == 1) hold_armed = 1'b1;
        drive_stream();
        wait_drained();
      end
    end

    $display("covered %0d input bytes, %0d tags, %0d sections closed, %0d overruns",
             sb.n_in, sb.n_out, sb.sections_closed, sb.role_hits[ROLE_OVERRUN]);
    $display("tags seen: %0d bad opcodes, %0d markers, %0d data, %0d signs, %0d cb subops",
             sb.role_hits[ROLE_BAD_OP], sb.role_hits[ROLE_MARKER],
             sb.role_hits[ROLE_DATA], sb.role_hits[ROLE_SIGN], sb.role_hits[ROLE_CB_SUB]);
    if (sb.errors == 0 && sb.pending_tags.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d errors, %0d tags never seen", sb.errors, sb.pending_tags.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== object_code_stream_decoder.f =====
design/ocsd_pkg.sv
design/ocsd_in_if.sv
design/ocsd_out_if.sv
design/object_code_stream_decoder.sv
tb/tb_object_code_stream_decoder.sv
